>>> src/pcar_pkg.sv
`timescale 1ns / 1ps

package pcar_pkg;

  localparam int MAX_WINDOWS_DEF = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW0      = 3'd1;

  // request type bits
  localparam int REQ_WRITE_BIT  = 0;
  localparam int REQ_LEGACY_BIT = 1;

  // access sizes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;

  typedef enum logic [1:0] {
    ROUTE_ECAM   = 2'd0,
    ROUTE_LEGACY = 2'd1,
    ROUTE_NONE   = 2'd2
  } route_t;

endpackage

>>> src/pcar_if.sv
`timescale 1ns / 1ps

interface pcar_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  access_size;
  logic [15:0] segment_id;
  logic [7:0]  bus_number;
  logic [4:0]  device_number;
  logic [2:0]  function_number;
  logic [11:0] register_offset;
  logic [31:0] write_value;
  logic [31:0] current_dword;

  modport source (
    output valid, req_type, access_size, segment_id, bus_number, device_number,
           function_number, register_offset, write_value, current_dword,
    input  ready
  );
  modport sink (
    input  valid, req_type, access_size, segment_id, bus_number, device_number,
           function_number, register_offset, write_value, current_dword,
    output ready
  );
endinterface

interface pcar_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  route;
  logic [1:0]  window_index;
  logic [27:0] window_offset;
  logic [31:0] legacy_address;
  logic [31:0] read_value;
  logic [31:0] write_dword;
  logic        write_enable;

  modport source (
    output valid, route, window_index, window_offset, legacy_address, read_value,
           write_dword, write_enable,
    input  ready
  );
  modport sink (
    input  valid, route, window_index, window_offset, legacy_address, read_value,
           write_dword, write_enable,
    output ready
  );
endinterface

>>> src/pcie_config_access_router_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Contents
// req     | in  | one config access: type, size, seg/bus/dev/fn, offset, data, current dword
// rsp     | out | route, window index/offset, legacy address, read data, merged write
// cfg     | in  | cfg_we / cfg_index / cfg_data: window count and four window registers
//
// Three register stages: window compare, route/address select, lane extract/merge.
// One transfer per cycle is sustained while rsp.ready is high; each stage stalls on its own.
// rst (synchronous) clears config registers and all stage valid bits.
// A stalled output holds; bubbles inside the pipe are squeezed out.

module pcie_config_access_router_top import pcar_pkg::*; #(
  parameter int MaxWindows = MAX_WINDOWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  pcar_req_if.sink               req,
  pcar_rsp_if.source             rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WidxW = (MaxWindows > 1) ? $clog2(MaxWindows) : 1;

  // configuration
  logic [2:0]  window_count;
  logic [31:0] windows [MaxWindows];
  logic [2:0]  limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      for (int i = 0; i < MaxWindows; i++) windows[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_COUNT) window_count <= cfg_data[2:0];
      for (int i = 0; i < MaxWindows; i++) begin
        if (cfg_index == REG_WINDOW0 + CFG_INDEX_W'(i)) windows[i] <= cfg_data;
      end
    end
  end

  assign limit = (window_count > 3'(MaxWindows)) ? 3'(MaxWindows) : window_count;

  // handshake chain
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready  = !s3_valid || rsp.ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req.ready = s1_ready;

  // stage 1: window compare
  logic                  in_legacy;
  logic [15:0]           in_seg;
  logic [11:0]           in_off;
  logic [MaxWindows-1:0] in_match;

  logic                  s1_write;
  logic                  s1_legacy;
  logic [1:0]            s1_size;
  logic [7:0]            s1_bus;
  logic [4:0]            s1_dev;
  logic [2:0]            s1_fn;
  logic [11:0]           s1_off;
  logic [31:0]           s1_wval;
  logic [31:0]           s1_cur;
  logic [MaxWindows-1:0] s1_match;

  always_comb begin
    in_legacy = req.req_type[REQ_LEGACY_BIT];
    in_seg    = in_legacy ? 16'd0 : req.segment_id;
    in_off    = in_legacy ? {4'd0, req.register_offset[7:0]} : req.register_offset;
    for (int i = 0; i < MaxWindows; i++) begin
      in_match[i] = (3'(i) < limit) && (windows[i][15:0] == in_seg) &&
                    (req.bus_number >= windows[i][23:16]) &&
                    (req.bus_number <= windows[i][31:24]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && req.valid) begin
      s1_write  <= req.req_type[REQ_WRITE_BIT];
      s1_legacy <= in_legacy;
      s1_size   <= (req.access_size > SIZE_DWORD) ? SIZE_DWORD : req.access_size;
      s1_bus    <= req.bus_number;
      s1_dev    <= req.device_number;
      s1_fn     <= req.function_number;
      s1_off    <= in_off;
      s1_wval   <= req.write_value;
      s1_cur    <= req.current_dword;
      s1_match  <= in_match;
    end
  end

  // stage 2: pick first matching window, build addresses and lane controls
  logic             s1_hit;
  logic [WidxW-1:0] s1_idx;
  logic [7:0]       s1_sbus;
  route_t           s1_route;
  logic [31:0]      s1_mask;
  logic [4:0]       s1_shift;

  route_t      s2_route;
  logic [1:0]  s2_widx;
  logic [27:0] s2_woff;
  logic [31:0] s2_laddr;
  logic        s2_write;
  logic [31:0] s2_mask;
  logic [4:0]  s2_shift;
  logic [31:0] s2_wval;
  logic [31:0] s2_cur;

  always_comb begin
    s1_hit = |s1_match;
    s1_idx = '0;
    for (int i = MaxWindows - 1; i >= 0; i--) begin
      if (s1_match[i]) s1_idx = WidxW'(i);
    end
    s1_sbus = windows[s1_idx][23:16];
    if (s1_hit)         s1_route = ROUTE_ECAM;
    else if (s1_legacy) s1_route = ROUTE_LEGACY;
    else                s1_route = ROUTE_NONE;
    unique case (s1_size)
      SIZE_BYTE: begin
        s1_mask  = 32'h0000_00FF;
        s1_shift = {s1_off[1:0], 3'd0};
      end
      SIZE_WORD: begin
        s1_mask  = 32'h0000_FFFF;
        s1_shift = {s1_off[1], 4'd0};
      end
      default: begin
        s1_mask  = 32'hFFFF_FFFF;
        s1_shift = 5'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_route <= s1_route;
      s2_widx  <= s1_hit ? 2'(s1_idx) : 2'd0;
      s2_woff  <= s1_hit ? {s1_bus - s1_sbus, s1_dev, s1_fn, s1_off[11:2], 2'b00} : '0;
      s2_laddr <= (s1_route == ROUTE_LEGACY) ?
                  {1'b1, 7'd0, s1_bus, s1_dev, s1_fn, s1_off[7:2], 2'b00} : '0;
      s2_write <= s1_write;
      s2_mask  <= s1_mask;
      s2_shift <= s1_shift;
      s2_wval  <= s1_wval;
      s2_cur   <= s1_cur;
    end
  end

  // stage 3: lane extract / merge into the output register
  logic [31:0] s2_rval;
  logic [31:0] s2_wdword;
  logic        s2_wen;

  always_comb begin
    s2_rval   = '0;
    s2_wdword = '0;
    s2_wen    = 1'b0;
    if (!s2_write) begin
      s2_rval = (s2_route == ROUTE_NONE) ? s2_mask : ((s2_cur >> s2_shift) & s2_mask);
    end else if (s2_route != ROUTE_NONE) begin
      s2_wdword = (s2_cur & ~(s2_mask << s2_shift)) | ((s2_wval & s2_mask) << s2_shift);
      s2_wen    = 1'b1;
    end
  end

  route_t      s3_route;
  logic [1:0]  s3_widx;
  logic [27:0] s3_woff;
  logic [31:0] s3_laddr;
  logic [31:0] s3_rval;
  logic [31:0] s3_wdword;
  logic        s3_wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_route  <= s2_route;
      s3_widx   <= s2_widx;
      s3_woff   <= s2_woff;
      s3_laddr  <= s2_laddr;
      s3_rval   <= s2_rval;
      s3_wdword <= s2_wdword;
      s3_wen    <= s2_wen;
    end
  end

  assign rsp.valid          = s3_valid;
  assign rsp.route          = s3_route;
  assign rsp.window_index   = s3_widx;
  assign rsp.window_offset  = s3_woff;
  assign rsp.legacy_address = s3_laddr;
  assign rsp.read_value     = s3_rval;
  assign rsp.write_dword    = s3_wdword;
  assign rsp.write_enable   = s3_wen;

endmodule

>>> src/pcar_checker.sv
`timescale 1ns / 1ps

module pcar_checker import pcar_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  route,
  input logic [1:0]  window_index,
  input logic [27:0] window_offset,
  input logic [31:0] legacy_address,
  input logic [31:0] read_value,
  input logic        write_enable
);

  // held transfer stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("rsp valid right after reset");

  a_wen_route: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && write_enable |-> route != ROUTE_NONE && read_value == 32'd0)
    else $error("write enabled without target or with read data");

  a_ecam_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && route != ROUTE_ECAM |-> window_index == 2'd0 && window_offset == 28'd0)
    else $error("window fields set on non-ECAM route");

  a_legacy_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((route == ROUTE_LEGACY) == legacy_address[31]))
    else $error("legacy address enable mismatch");

endmodule

bind pcie_config_access_router_top pcar_checker u_pcar_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .route          (rsp.route),
  .window_index   (rsp.window_index),
  .window_offset  (rsp.window_offset),
  .legacy_address (rsp.legacy_address),
  .read_value     (rsp.read_value),
  .write_enable   (rsp.write_enable)
);
